/* design/stsc_pkg.sv */
// Shared constants and types for the signed target sum counter.
package stsc_pkg;

    localparam int ROW_ENTRIES = 1024;
    localparam int COUNT_WIDTH = 32;
    localparam int ADDR_W      = $clog2(ROW_ENTRIES);
    localparam int ELEM_W      = 10;
    localparam int TOTAL_W     = 11;
    localparam int TARGET_W    = 11;
    localparam int OUT_W       = 32;
    localparam int TOTAL_MAX   = (1 << TOTAL_W) - 1;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [ADDR_W-1:0]      addr_t;

endpackage

/* design/stsc_row_ram.sv */
// Two-read, one-write synchronous RAM holding the row of subset counts.
module stsc_row_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* design/signed_target_sum_counter_top.sv */
// An accepted element sweeps the row RAM from the top entry down to its own value, then
// passes a drain state and returns to idle. A last element goes on through a read state
// to the result state, which waits for a free output slot, then a clear pass writes the row.
// No new element is taken until the block is back in idle; the row sweep does one RAM
// read-modify-write per cycle. The result beat waits in a register while the clear runs.
// Reset: rst_n clears control, total, flag and target, then a clear pass writes the row before in_ready rises.
module signed_target_sum_counter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic signed [stsc_pkg::TARGET_W-1:0] cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [stsc_pkg::ELEM_W-1:0]         element_value,
    input  logic                                last_element,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [stsc_pkg::OUT_W-1:0]          way_count,
    output logic                                overflow_flag
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SWEEP  = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;
    localparam logic [2:0] ST_CLEAR  = 3'd5;

    localparam int CW = stsc_pkg::COUNT_WIDTH;
    localparam int AW = stsc_pkg::ADDR_W;
    localparam int TW = stsc_pkg::TOTAL_W;
    localparam int GW = stsc_pkg::TARGET_W;

    logic [2:0] state_reg, state_next;
    stsc_pkg::addr_t s_reg, s_next;
    stsc_pkg::addr_t clr_reg, clr_next;
    stsc_pkg::addr_t wr_addr_reg, wr_addr_next;
    logic wr_pend_reg, wr_pend_next;
    logic [stsc_pkg::ELEM_W-1:0] e_reg, e_next;
    logic last_reg, last_next;
    logic [TW-1:0] total_reg, total_next;
    logic sticky_reg, sticky_next;
    logic half_ok_reg, half_ok_next;
    logic signed [GW-1:0] target_reg;
    logic out_valid_reg, out_valid_next;
    logic [stsc_pkg::OUT_W-1:0] way_reg, way_next;
    logic flag_reg, flag_next;

    logic ram_we, ram_re;
    stsc_pkg::addr_t ram_waddr, ram_ra, ram_rb;
    stsc_pkg::count_t ram_wdata, rd_a, rd_b;

    stsc_pkg::addr_t e_addr;
    logic [CW:0] pair_sum;
    stsc_pkg::count_t sat_data;
    logic [TW:0] total_sum;
    logic [TW-1:0] total_new;
    logic signed [GW+1:0] diff;
    logic [GW-1:0] half_val;
    logic half_ok;
    logic wide;

    stsc_row_ram #(
        .DEPTH(stsc_pkg::ROW_ENTRIES),
        .WIDTH(CW)
    ) u_row_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_ra),
        .raddr_b (ram_rb),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    assign e_addr   = AW'(e_reg);
    assign pair_sum = {1'b0, rd_a} + {1'b0, rd_b};
    assign sat_data = pair_sum[CW] ? {CW{1'b1}} : pair_sum[CW-1:0];

    assign total_sum = {1'b0, total_reg} + (TW + 1)'(element_value);
    assign total_new = (32'(total_sum) > stsc_pkg::TOTAL_MAX)
                       ? TW'(stsc_pkg::TOTAL_MAX) : total_sum[TW-1:0];

    // difference is (total - target); half index valid only if non-negative and even
    assign diff     = $signed({2'b00, total_reg}) - $signed({{2{target_reg[GW-1]}}, target_reg});
    assign half_val = diff[GW:1];
    assign half_ok  = !diff[GW+1] && !diff[0] && (32'(half_val) < stsc_pkg::ROW_ENTRIES);

    assign wide = 64'(rd_a) > 64'h0000_0000_FFFF_FFFF;

    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        clr_next       = clr_reg;
        wr_addr_next   = wr_addr_reg;
        wr_pend_next   = 1'b0;
        e_next         = e_reg;
        last_next      = last_reg;
        total_next     = total_reg;
        sticky_next    = sticky_reg;
        half_ok_next   = half_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        way_next       = way_reg;
        flag_next      = flag_reg;
        ram_re         = 1'b0;
        ram_ra         = s_reg;
        ram_rb         = s_reg - e_addr;
        ram_we         = 1'b0;
        ram_waddr      = wr_addr_reg;
        ram_wdata      = sat_data;

        // write-back stage of the sweep
        if (wr_pend_reg)
        begin
            ram_we = 1'b1;
            if (pair_sum[CW])
            begin
                sticky_next = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    e_next     = element_value;
                    last_next  = last_element;
                    total_next = total_new;
                    if ((32'(total_sum) > stsc_pkg::TOTAL_MAX)
                        || (32'(total_new) > stsc_pkg::ROW_ENTRIES - 1))
                    begin
                        sticky_next = 1'b1;
                    end
                    if (32'(element_value) < stsc_pkg::ROW_ENTRIES)
                    begin
                        s_next     = AW'(stsc_pkg::ROW_ENTRIES - 1);
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_SWEEP:
            begin
                // descending sweep: reads never hit an entry already rewritten
                ram_re       = 1'b1;
                wr_pend_next = 1'b1;
                wr_addr_next = s_reg;
                if (s_reg == e_addr)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    s_next = s_reg - 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = last_reg ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                ram_re       = 1'b1;
                ram_ra       = AW'(half_val);
                half_ok_next = half_ok;
                state_next   = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (half_ok_reg)
                    begin
                        way_next  = wide ? {stsc_pkg::OUT_W{1'b1}} : stsc_pkg::OUT_W'(rd_a);
                        flag_next = sticky_reg || wide;
                    end
                    else
                    begin
                        way_next  = '0;
                        flag_next = sticky_reg;
                    end
                    total_next  = '0;
                    sticky_next = 1'b0;
                    clr_next    = '0;
                    state_next  = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = (clr_reg == '0) ? CW'(1) : '0;
                if (clr_reg == AW'(stsc_pkg::ROW_ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            total_reg     <= '0;
            sticky_reg    <= 1'b0;
            target_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wr_pend_reg   <= wr_pend_next;
            total_reg     <= total_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg       <= s_next;
        wr_addr_reg <= wr_addr_next;
        e_reg       <= e_next;
        last_reg    <= last_next;
        half_ok_reg <= half_ok_next;
        way_reg     <= way_next;
        flag_reg    <= flag_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign way_count     = way_reg;
    assign overflow_flag = flag_reg;

    // no write-back may be left over once a new beat can be taken
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !wr_pend_reg)
        else $error("row write pending while idle");

    // sweep address never goes below the element
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (s_reg >= e_addr))
        else $error("sweep ran below element");

    // an accepted beat always starts a sweep or goes straight to drain
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SWEEP || state_reg == ST_DRAIN))
        else $error("accepted beat did not start");

    // a result is loaded only into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && $past(state_reg) == ST_RESULT && out_valid_reg)
        |-> !$past(out_ready))
        else $error("result stall without output backpressure");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for signed_target_sum_counter_top: directed sets, then random sets.
`timescale 1ns / 1ps

module testbench;

    localparam int ROW_ENTRIES = stsc_pkg::ROW_ENTRIES;
    localparam int COUNT_WIDTH = stsc_pkg::COUNT_WIDTH;
    localparam int ADDR_W      = stsc_pkg::ADDR_W;
    localparam int ELEM_W      = stsc_pkg::ELEM_W;
    localparam int TOTAL_W     = stsc_pkg::TOTAL_W;
    localparam int TARGET_W    = stsc_pkg::TARGET_W;
    localparam int OUT_W       = stsc_pkg::OUT_W;
    localparam int TOTAL_MAX   = stsc_pkg::TOTAL_MAX;

    localparam int PLAN_LEN      = 21;
    // a full row sweep, the result beat and the clear pass that follows it
    localparam int SETTLE_CYCLES = 2 * ROW_ENTRIES + 64;
    localparam int CYCLE_LIMIT   = 6_000_000;

    typedef struct packed {
        logic [OUT_W-1:0] ways;
        logic             flag;
    } tally_t;

    typedef struct {
        logic signed [TARGET_W-1:0] target;
        logic [ELEM_W-1:0]          elem;
        logic                       last;
        logic                       typed;
        logic [OUT_W-1:0]           ways;
        logic                       flag;
    } plan_row_t;

    typedef enum {SET_SMALL, SET_WIDE, SET_HEAVY, SET_SATURATE} set_kind_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic signed [TARGET_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [ELEM_W-1:0] element_value = '0;
    logic last_element = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [OUT_W-1:0] way_count;
    logic overflow_flag;

    // hand-typed result travels with the beat that closes a directed set
    logic typed_hold = 1'b0;
    logic [OUT_W-1:0] typed_ways = '0;
    logic typed_flag = 1'b0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int mismatches = 0;
    logic signed [TARGET_W-1:0] cur_target = '0;

    // subset-count row and set state mirrored from the block
    logic [COUNT_WIDTH-1:0] subset_row [ROW_ENTRIES];
    logic [TOTAL_W-1:0] total_model;
    logic ovf_model;
    logic signed [TARGET_W-1:0] target_model = '0;
    tally_t ways_due [$];

    plan_row_t plan [PLAN_LEN] = '{
        // target 0: zero first element gives two ways; odd difference; +1-1 / -1+1
        '{0, 0, 1, 1, 2, 0},
        '{0, 1023, 1, 1, 0, 0},
        '{0, 1, 0, 0, 0, 0},
        '{0, 1, 1, 1, 2, 0},
        '{0, 3, 0, 0, 0, 0},
        '{0, 5, 0, 0, 0, 0},
        '{0, 7, 0, 0, 0, 0},
        '{0, 1, 0, 0, 0, 0},
        '{0, 4, 1, 0, 0, 0},
        // negative difference
        '{5, 2, 1, 1, 0, 0},
        // largest target met exactly by the largest element
        '{1023, 1023, 1, 1, 1, 0},
        // total past the row, then total saturation with half beyond the row
        '{-1023, 1023, 0, 0, 0, 0},
        '{-1023, 1023, 1, 1, 0, 1},
        '{-1023, 1023, 0, 0, 0, 0},
        '{-1023, 1023, 0, 0, 0, 0},
        '{-1023, 1023, 1, 1, 0, 1},
        '{-1023, 512, 0, 0, 0, 0},
        '{-1023, 511, 1, 0, 0, 0},
        '{-1, 0, 0, 0, 0, 0},
        '{-1, 0, 0, 0, 0, 0},
        '{-1, 1, 1, 0, 0, 0}
    };

    signed_target_sum_counter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .last_element  (last_element),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .way_count     (way_count),
        .overflow_flag (overflow_flag)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);

    task automatic clear_sums();
        for (int s = 0; s < ROW_ENTRIES; s++)
            subset_row[ADDR_W'(s)] = '0;
        subset_row[0] = COUNT_WIDTH'(1);
        total_model = '0;
        ovf_model = 1'b0;
    endtask

    initial clear_sums();

    task automatic fold_element(input logic [ELEM_W-1:0] e, input logic last);
        logic [COUNT_WIDTH:0] acc;
        int sum;
        int diff;
        tally_t due;
        // walk downward so every term reads the row as it was before this element
        for (int s = ROW_ENTRIES - 1; s >= int'(e); s--)
        begin
            acc = {1'b0, subset_row[ADDR_W'(s)]} + {1'b0, subset_row[ADDR_W'(s - int'(e))]};
            if (acc[COUNT_WIDTH])
            begin
                subset_row[ADDR_W'(s)] = '1;
                ovf_model = 1'b1;
            end
            else
                subset_row[ADDR_W'(s)] = acc[COUNT_WIDTH-1:0];
        end
        sum = int'(total_model) + int'(e);
        if (sum > TOTAL_MAX)
        begin
            total_model = TOTAL_W'(TOTAL_MAX);
            ovf_model = 1'b1;
        end
        else
            total_model = TOTAL_W'(sum);
        if (int'(total_model) > ROW_ENTRIES - 1)
            ovf_model = 1'b1;
        if (last)
        begin
            diff = int'(total_model) - int'(target_model);
            due.ways = '0;
            due.flag = ovf_model;
            if (diff >= 0 && diff % 2 == 0 && diff / 2 < ROW_ENTRIES)
                due.ways = subset_row[ADDR_W'(diff / 2)];
            if (typed_hold)
            begin
                due.ways = typed_ways;
                due.flag = typed_flag;
            end
            ways_due.push_back(due);
            clear_sums();
        end
    endtask

    always @(posedge clk)
    begin
        tally_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                target_model = cfg_wr_data;
            if (in_valid && in_ready)
                fold_element(element_value, last_element);
            if (out_valid && out_ready)
            begin
                if (ways_due.size() == 0)
                begin
                    $error("result beat with no set pending: way_count %0d", way_count);
                    mismatches++;
                end
                else
                begin
                    want = ways_due.pop_front();
                    if (way_count !== want.ways)
                    begin
                        $error("way_count: expected %0d, actual %0d", want.ways, way_count);
                        mismatches++;
                    end
                    if (overflow_flag !== want.flag)
                    begin
                        $error("overflow_flag: expected %0d, actual %0d",
                               want.flag, overflow_flag);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic push_element(input logic [ELEM_W-1:0] e, input logic last,
                                input logic typed, input logic [OUT_W-1:0] ways,
                                input logic flag);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct)
            gap++;
        // now and then a long gap so valid rises at another point of the sweep
        if (gap != 0 && $urandom_range(15) == 0)
            gap = int'($urandom_range(1100, 1));
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        element_value <= e;
        last_element <= last;
        typed_hold <= typed;
        typed_ways <= ways;
        typed_flag <= flag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ways_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic retarget(input logic signed [TARGET_W-1:0] v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_target = v;
    endtask

    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        set_kind_t kind;
        int len;
        int sent;
        int pick;
        logic [ELEM_W-1:0] e;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        retarget('0);

        tx_idle_pct = 20;
        rx_idle_pct = 68;
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if ((i == 0 || plan[i-1].last) && plan[i].target != cur_target)
                retarget(plan[i].target);
            push_element(plan[i].elem, plan[i].last, plan[i].typed, plan[i].ways,
                         plan[i].flag);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 68 : 0;
            rx_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 20 : 0;
            for (int sub = 0; sub < 4; sub++)
            begin
                if (sub == 1)
                    retarget('0);
                else if (sub == 3)
                    retarget(TARGET_W'(int'($urandom_range(2046)) - 1023));
                else
                    retarget(TARGET_W'(int'($urandom_range(40)) - 20));
                sent = 0;
                while (sent < 44)
                begin
                    pick = int'($urandom_range(99));
                    if (sub == 1 && sent == 0)
                        kind = SET_SATURATE;
                    else if (pick < 62)
                        kind = SET_SMALL;
                    else if (pick < 87)
                        kind = SET_WIDE;
                    else
                        kind = SET_HEAVY;
                    unique case (kind)
                        SET_SMALL: len = int'($urandom_range(10, 1));
                        SET_WIDE:  len = int'($urandom_range(4, 1));
                        SET_HEAVY: len = int'($urandom_range(5, 2));
                        default:   len = 34;
                    endcase
                    for (int k = 0; k < len; k++)
                    begin
                        unique case (kind)
                            SET_SMALL: e = ELEM_W'($urandom_range(15));
                            SET_WIDE:  e = ELEM_W'($urandom_range(1023));
                            SET_HEAVY: e = ELEM_W'($urandom_range(1023, 600));
                            // mostly zeros: each one doubles the row until counts pin
                            default:   e = ($urandom_range(7) == 0) ? ELEM_W'(2) : '0;
                        endcase
                        push_element(e, k == len - 1, 1'b0, '0, 1'b0);
                    end
                    sent += len;
                    if (kind == SET_SATURATE || $urandom_range(7) == 0)
                        drain_results();
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
design/stsc_pkg.sv
design/stsc_row_ram.sv
design/signed_target_sum_counter_top.sv
tb/sv/testbench.sv
